// File: hw/rtl/drsa_pkg.sv
// ----------------------------------------------------------------------------
// drsa_pkg
// Types and constants shared by the deferred reclaim slot allocator.
// ----------------------------------------------------------------------------
package drsa_pkg;

   localparam int MAX_SLOTS       = 256;
   localparam int TEXELS_PER_EDGE = 136;

   localparam int SLOT_W     = $clog2(MAX_SLOTS);
   localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
   localparam int STAMP_W    = 64;
   localparam int OFFSET_W   = 27;
   localparam int BPT_W      = 5;
   localparam int BPT_MAX    = 16;
   localparam int BPT_RESET  = 4;
   localparam int DELAY_W    = 8;
   localparam int DELAY_RESET = 3;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 2;

   localparam int TILE_TEXELS = TEXELS_PER_EDGE * TEXELS_PER_EDGE;
   localparam int TILE_MAX    = TILE_TEXELS * BPT_MAX;
   localparam int TILE_W      = $clog2(TILE_MAX + 1);
   localparam int MUL_W       = SLOT_W + TILE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_LIMIT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_TEXEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECLAIM_DELAY   = 2'd2;

   typedef enum logic [1:0] {
      ACT_RESERVE = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_RECLAIM = 2'd2,
      ACT_QUERY   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_EXHAUSTED = 2'd1,
      STS_NO_SLOT   = 2'd2,
      STS_NOT_HELD  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      COND_FREE = 2'd0,
      COND_HELD = 2'd1,
      COND_QUAR = 2'd2
   } cond_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         slot_number;
      logic [STAMP_W-1:0] recording_index;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [7:0]          granted_slot;
      logic [OFFSET_W-1:0] byte_offset;
      logic [8:0]          reclaimed_count;
      logic [8:0]          held_count;
      logic [8:0]          quarantined_count;
      logic [8:0]          free_count;
   } rsp_type;

endpackage

// File: hw/rtl/drsa_ram.sv
// ----------------------------------------------------------------------------
// drsa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module drsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/deferred_reclaim_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// deferred_reclaim_slot_allocator_top
// Slot pool with a lifo free stack and quarantine before reuse.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command word (reserve, release, reclaim, offset query).
//   rsp_* returns exactly one result word per command, with the held,
//   quarantined and free totals after the command.
//   csr_* writes slot_limit, bytes_per_texel and reclaim_delay; it is always
//   ready and must only be used while no command is in flight. Writing
//   a nonzero slot_limit frees every slot and refills the stack, slot 0 on top.
// Command path from request accept to result valid:
//   offset query, exhausted pool or bad slot: ST_EXEC, then ST_OUT
//   reserve and release: ST_EXEC, ST_RSV or ST_REL, then ST_OUT
//   reclaim: ST_EXEC, then ST_REC_RD and ST_REC_EV for every slot below
//   slot_limit, then ST_OUT; ST_REC_RD covers the registered memory read
// One command is processed at a time; req_ready is high only while idle,
// so the next command is accepted only once the last has left ST_OUT.
// A finished result sits in the output register while the next command
// runs; a command whose result is ready holds until that register empties.
// Reset is synchronous; the pool comes up with 256 free slots at once.
// ----------------------------------------------------------------------------
module deferred_reclaim_slot_allocator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  drsa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output drsa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [drsa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [drsa_pkg::CSR_DATA_W-1:0]     csr_data
);

   import drsa_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EXEC   = 7'b0000010,
      ST_RSV    = 7'b0000100,
      ST_REL    = 7'b0001000,
      ST_REC_RD = 7'b0010000,
      ST_REC_EV = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   req_type              item_ff, item_in;
   logic [CNT_W-1:0]     limit_ff, limit_in;
   logic [TILE_W-1:0]    tile_ff, tile_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic [CNT_W-1:0]     depth_ff, depth_in;
   logic [CNT_W-1:0]     held_ff, held_in;
   logic [CNT_W-1:0]     quar_ff, quar_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   status_type           res_status_ff, res_status_in;
   logic [SLOT_W-1:0]    res_granted_ff, res_granted_in;
   logic [OFFSET_W-1:0]  res_offset_ff, res_offset_in;
   logic [CNT_W-1:0]     res_reclaimed_ff, res_reclaimed_in;
   logic [MAX_SLOTS-1:0] cond_vld_ff, cond_vld_in;
   logic [MAX_SLOTS-1:0] stk_vld_ff, stk_vld_in;
   logic                 cond_vld_rd_ff, cond_vld_rd_in;
   logic                 stk_vld_rd_ff, stk_vld_rd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 cond_wr_en;
   logic [SLOT_W-1:0]    cond_wr_addr;
   logic [1:0]           cond_wr_data;
   logic [SLOT_W-1:0]    cond_rd_addr;
   logic [1:0]           cond_rd_data;
   logic [1:0]           cond_eff;
   logic                 stamp_wr_en;
   logic [STAMP_W-1:0]   stamp_rd_data;
   logic                 stk_wr_en;
   logic [SLOT_W-1:0]    stk_wr_addr;
   logic [SLOT_W-1:0]    stk_wr_data;
   logic [SLOT_W-1:0]    stk_rd_addr;
   logic [SLOT_W-1:0]    stk_rd_data;
   logic [SLOT_W-1:0]    pop_slot;
   logic [SLOT_W-1:0]    mul_a;
   logic [MUL_W-1:0]     mul_y;
   logic [STAMP_W:0]     age;
   logic                 age_ok;
   logic [CNT_W-1:0]     limit_wr;
   logic [BPT_W-1:0]     bpt_wr;

   drsa_ram #(.WIDTH(2), .DEPTH(MAX_SLOTS)) u_cond_ram (
      .clock   (clock),
      .wr_en   (cond_wr_en),
      .wr_addr (cond_wr_addr),
      .wr_data (cond_wr_data),
      .rd_addr (cond_rd_addr),
      .rd_data (cond_rd_data)
   );

   drsa_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_SLOTS)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_wr_en),
      .wr_addr (item_ff.slot_number[SLOT_W-1:0]),
      .wr_data (item_ff.recording_index),
      .rd_addr (idx_ff[SLOT_W-1:0]),
      .rd_data (stamp_rd_data)
   );

   drsa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // never-written entries read as their reset contents
   assign cond_eff = cond_vld_rd_ff ? cond_rd_data : COND_FREE;
   assign pop_slot = stk_vld_rd_ff ? stk_rd_data : SLOT_W'(limit_ff - depth_ff);

   assign mul_a = (state_ff == ST_RSV) ? pop_slot : item_ff.slot_number[SLOT_W-1:0];
   assign mul_y = MUL_W'(mul_a) * MUL_W'(tile_ff);

   assign age    = {1'b0, item_ff.recording_index} - {1'b0, stamp_rd_data};
   assign age_ok = !age[STAMP_W]
                   && ((|age[STAMP_W-1:DELAY_W]) || (age[DELAY_W-1:0] >= delay_ff));

   assign cond_rd_addr = (state_ff == ST_REC_RD) ? idx_ff[SLOT_W-1:0]
                                                  : item_ff.slot_number[SLOT_W-1:0];
   assign stk_rd_addr  = SLOT_W'(depth_ff - CNT_W'(1));
   assign stk_wr_addr  = depth_ff[SLOT_W-1:0];
   assign stk_wr_data  = idx_ff[SLOT_W-1:0];

   assign limit_wr = (csr_data > CSR_DATA_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                         : CNT_W'(csr_data);
   assign bpt_wr   = (csr_data[BPT_W-1:0] > BPT_W'(BPT_MAX)) ? BPT_W'(BPT_MAX)
                                                             : csr_data[BPT_W-1:0];

   always_comb begin
      state_in         = state_ff;
      item_in          = item_ff;
      limit_in         = limit_ff;
      tile_in          = tile_ff;
      delay_in         = delay_ff;
      depth_in         = depth_ff;
      held_in          = held_ff;
      quar_in          = quar_ff;
      idx_in           = idx_ff;
      res_status_in    = res_status_ff;
      res_granted_in   = res_granted_ff;
      res_offset_in    = res_offset_ff;
      res_reclaimed_in = res_reclaimed_ff;
      cond_vld_in      = cond_vld_ff;
      stk_vld_in       = stk_vld_ff;
      cond_vld_rd_in   = cond_vld_ff[cond_rd_addr];
      stk_vld_rd_in    = stk_vld_ff[stk_rd_addr];
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_data_in      = rsp_data_ff;
      cond_wr_en       = 1'b0;
      cond_wr_addr     = item_ff.slot_number[SLOT_W-1:0];
      cond_wr_data     = COND_FREE;
      stamp_wr_en      = 1'b0;
      stk_wr_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_status_in    = STS_OK;
            res_granted_in   = '0;
            res_offset_in    = '0;
            res_reclaimed_in = '0;
            state_in         = ST_OUT;
            case (item_ff.action)
               ACT_RESERVE: begin
                  if (depth_ff == '0) begin
                     res_status_in = STS_EXHAUSTED;
                  end else begin
                     state_in = ST_RSV;
                  end
               end
               ACT_RELEASE: begin
                  if (CNT_W'(item_ff.slot_number) >= limit_ff) begin
                     res_status_in = STS_NO_SLOT;
                  end else begin
                     state_in = ST_REL;
                  end
               end
               ACT_RECLAIM: begin
                  idx_in   = '0;
                  state_in = ST_REC_RD;
               end
               ACT_QUERY: begin
                  if (CNT_W'(item_ff.slot_number) >= limit_ff) begin
                     res_status_in = STS_NO_SLOT;
                  end else begin
                     res_offset_in = mul_y[OFFSET_W-1:0];
                  end
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_RSV: begin
            cond_wr_en            = 1'b1;
            cond_wr_addr          = pop_slot;
            cond_wr_data          = COND_HELD;
            cond_vld_in[pop_slot] = 1'b1;
            depth_in              = depth_ff - CNT_W'(1);
            held_in               = held_ff + CNT_W'(1);
            res_granted_in        = pop_slot;
            res_offset_in         = mul_y[OFFSET_W-1:0];
            state_in              = ST_OUT;
         end
         ST_REL: begin
            if (cond_eff != COND_HELD) begin
               res_status_in = STS_NOT_HELD;
            end else begin
               cond_wr_en   = 1'b1;
               cond_wr_data = COND_QUAR;
               cond_vld_in[item_ff.slot_number[SLOT_W-1:0]] = 1'b1;
               stamp_wr_en  = 1'b1;
               held_in      = held_ff - CNT_W'(1);
               quar_in      = quar_ff + CNT_W'(1);
            end
            state_in = ST_OUT;
         end
         ST_REC_RD: begin
            if (idx_ff >= limit_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_REC_EV;
            end
         end
         ST_REC_EV: begin
            if ((cond_eff == COND_QUAR) && age_ok) begin
               cond_wr_en   = 1'b1;
               cond_wr_addr = idx_ff[SLOT_W-1:0];
               cond_wr_data = COND_FREE;
               cond_vld_in[idx_ff[SLOT_W-1:0]] = 1'b1;
               if (depth_ff < CNT_W'(MAX_SLOTS)) begin
                  stk_wr_en                       = 1'b1;
                  stk_vld_in[depth_ff[SLOT_W-1:0]] = 1'b1;
                  depth_in                        = depth_ff + CNT_W'(1);
               end
               quar_in          = quar_ff - CNT_W'(1);
               res_reclaimed_in = res_reclaimed_ff + CNT_W'(1);
            end
            idx_in   = idx_ff + CNT_W'(1);
            state_in = ST_REC_RD;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.status            = res_status_ff;
               rsp_data_in.granted_slot      = 8'(res_granted_ff);
               rsp_data_in.byte_offset       = res_offset_ff;
               rsp_data_in.reclaimed_count   = 9'(res_reclaimed_ff);
               rsp_data_in.held_count        = 9'(held_ff);
               rsp_data_in.quarantined_count = 9'(quar_ff);
               rsp_data_in.free_count        = 9'(depth_ff);
               rsp_valid_in                  = 1'b1;
               state_in                      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         case (csr_index)
            CSR_SLOT_LIMIT: begin
               if (csr_data != '0) begin
                  limit_in    = limit_wr;
                  depth_in    = limit_wr;
                  held_in     = '0;
                  quar_in     = '0;
                  cond_vld_in = '0;
                  stk_vld_in  = '0;
               end
            end
            CSR_BYTES_PER_TEXEL: begin
               if (csr_data[BPT_W-1:0] != '0) begin
                  tile_in = TILE_W'(TILE_TEXELS) * TILE_W'(bpt_wr);
               end
            end
            CSR_RECLAIM_DELAY: begin
               delay_in = csr_data[DELAY_W-1:0];
            end
            default: begin
               delay_in = delay_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= CNT_W'(MAX_SLOTS);
         tile_ff      <= TILE_W'(TILE_TEXELS * BPT_RESET);
         delay_ff     <= DELAY_W'(DELAY_RESET);
         depth_ff     <= CNT_W'(MAX_SLOTS);
         held_ff      <= '0;
         quar_ff      <= '0;
         cond_vld_ff  <= '0;
         stk_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         tile_ff      <= tile_in;
         delay_ff     <= delay_in;
         depth_ff     <= depth_in;
         held_ff      <= held_in;
         quar_ff      <= quar_in;
         cond_vld_ff  <= cond_vld_in;
         stk_vld_ff   <= stk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff          <= item_in;
      idx_ff           <= idx_in;
      res_status_ff    <= res_status_in;
      res_granted_ff   <= res_granted_in;
      res_offset_ff    <= res_offset_in;
      res_reclaimed_ff <= res_reclaimed_in;
      cond_vld_rd_ff   <= cond_vld_rd_in;
      stk_vld_rd_ff    <= stk_vld_rd_in;
      rsp_data_ff      <= rsp_data_in;
   end

endmodule

// File: tb/deferred_reclaim_slot_allocator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deferred_reclaim_slot_allocator_top_test
// Drives reserve, release, reclaim and offset query words through the slot
// allocator and checks every result word against a cycle-free model of the
// pool, its lifo free stack and its quarantine, or a typed script result.
// A short scripted sequence covers field extremes and error codes, then
// random phases run with different register settings and idling patterns.
// ----------------------------------------------------------------------------
module deferred_reclaim_slot_allocator_top_test;
   import drsa_pkg::*;

   localparam int WATCHDOG_CYCLES = 4000;
   localparam int PHASES          = 6;
   localparam int PHASE_WORDS     = 90;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REGISTER = 2'd3;

   typedef struct {
      bit                    is_register;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      req_type               word;
      bit                    typed;
      rsp_type               typed_rsp;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // pool model
   logic [CNT_W-1:0]   cfg_limit;
   logic [BPT_W-1:0]   cfg_bpt;
   logic [DELAY_W-1:0] cfg_delay;
   cond_type           slot_state [MAX_SLOTS];
   logic [STAMP_W-1:0] slot_stamp [MAX_SLOTS];
   logic [SLOT_W-1:0]  free_slots [MAX_SLOTS];
   logic [CNT_W-1:0]   free_depth;
   logic [CNT_W-1:0]   held_now;
   logic [CNT_W-1:0]   quarantined_now;

   rsp_type            awaited_results [$];
   script_row_type     script [$];
   bit                 typed_pending = 1'b0;
   rsp_type            typed_value = '0;
   int                 mismatch_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 hold_stretch = 0;
   int                 quiet_cycles = 0;
   logic [STAMP_W-1:0] recording_now = '0;

   deferred_reclaim_slot_allocator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void refill_pool();
      for (int i = 0; i < MAX_SLOTS; i++) begin
         slot_state[i] = COND_FREE;
         slot_stamp[i] = '0;
      end
      for (int i = 0; i < cfg_limit; i++)
         free_slots[i] = SLOT_W'(cfg_limit - 1 - i);
      free_depth      = cfg_limit;
      held_now        = '0;
      quarantined_now = '0;
   endfunction

   function automatic void apply_register_write(logic [CSR_IDX_W-1:0] idx,
                                                logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_SLOT_LIMIT: begin
            if (val != 0) begin
               cfg_limit = (val > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(val);
               refill_pool();
            end
         end
         CSR_BYTES_PER_TEXEL: begin
            if (val[BPT_W-1:0] != 0)
               cfg_bpt = (val[BPT_W-1:0] > BPT_MAX) ? BPT_W'(BPT_MAX) : val[BPT_W-1:0];
         end
         CSR_RECLAIM_DELAY: cfg_delay = val[DELAY_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [OFFSET_W-1:0] offset_for(logic [SLOT_W-1:0] s);
      logic [63:0] prod;
      prod = 64'(s) * 64'(TILE_TEXELS) * 64'(cfg_bpt);
      return prod[OFFSET_W-1:0];
   endfunction

   function automatic rsp_type allocator_step(req_type w);
      rsp_type          r;
      logic [SLOT_W-1:0] s;
      r = '0;
      r.status = STS_OK;
      case (w.action)
         ACT_RESERVE: begin
            if (free_depth == 0) begin
               r.status = STS_EXHAUSTED;
            end else begin
               free_depth = free_depth - CNT_W'(1);
               s = free_slots[free_depth];
               slot_state[s] = COND_HELD;
               held_now = held_now + CNT_W'(1);
               r.granted_slot = s;
               r.byte_offset = offset_for(s);
            end
         end
         ACT_RELEASE: begin
            if (w.slot_number >= cfg_limit) begin
               r.status = STS_NO_SLOT;
            end else if (slot_state[w.slot_number] != COND_HELD) begin
               r.status = STS_NOT_HELD;
            end else begin
               slot_state[w.slot_number] = COND_QUAR;
               slot_stamp[w.slot_number] = w.recording_index;
               held_now = held_now - CNT_W'(1);
               quarantined_now = quarantined_now + CNT_W'(1);
            end
         end
         ACT_RECLAIM: begin
            for (int i = 0; i < cfg_limit; i++) begin
               if (slot_state[i] == COND_QUAR && w.recording_index >= slot_stamp[i] &&
                   (w.recording_index - slot_stamp[i]) >= 64'(cfg_delay)) begin
                  slot_state[i] = COND_FREE;
                  if (free_depth < MAX_SLOTS) begin
                     free_slots[free_depth] = SLOT_W'(i);
                     free_depth = free_depth + CNT_W'(1);
                  end
                  quarantined_now = quarantined_now - CNT_W'(1);
                  r.reclaimed_count = r.reclaimed_count + 9'(1);
               end
            end
         end
         default: begin
            if (w.slot_number >= cfg_limit)
               r.status = STS_NO_SLOT;
            else
               r.byte_offset = offset_for(w.slot_number);
         end
      endcase
      r.held_count        = held_now;
      r.quarantined_count = quarantined_now;
      r.free_count        = free_depth;
      return r;
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      rsp_type predicted;
      rsp_type want;
      if (reset) begin
         cfg_limit = CNT_W'(MAX_SLOTS);
         cfg_bpt   = BPT_W'(BPT_RESET);
         cfg_delay = DELAY_W'(DELAY_RESET);
         refill_pool();
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready)
            apply_register_write(csr_index, csr_data);
         if (req_valid && req_ready) begin
            predicted = allocator_step(req_data);
            if (typed_pending) begin
               awaited_results = {awaited_results, typed_value};
               typed_pending = 1'b0;
            end else begin
               awaited_results = {awaited_results, predicted};
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result word with nothing expected");
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("granted_slot", want.granted_slot, rsp_data.granted_slot);
               check_field("byte_offset", want.byte_offset, rsp_data.byte_offset);
               check_field("reclaimed_count", want.reclaimed_count, rsp_data.reclaimed_count);
               check_field("held_count", want.held_count, rsp_data.held_count);
               check_field("quarantined_count", want.quarantined_count,
                           rsp_data.quarantined_count);
               check_field("free_count", want.free_count, rsp_data.free_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_stretch > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_stretch) @(negedge clock);
            hold_stretch = 0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic rsp_type make_rsp(logic [1:0] status, int granted, int offset,
                                        int reclaimed, int held, int quar, int free_cnt);
      rsp_type r;
      r.status            = status;
      r.granted_slot      = 8'(granted);
      r.byte_offset       = OFFSET_W'(offset);
      r.reclaimed_count   = 9'(reclaimed);
      r.held_count        = 9'(held);
      r.quarantined_count = 9'(quar);
      r.free_count        = 9'(free_cnt);
      return r;
   endfunction

   function automatic void add_word(action_type act, logic [7:0] slot,
                                    logic [STAMP_W-1:0] ri, bit typed = 1'b0,
                                    rsp_type r = '0);
      script_row_type row;
      row.is_register           = 1'b0;
      row.reg_index             = '0;
      row.reg_value             = '0;
      row.word.action           = act;
      row.word.slot_number      = slot;
      row.word.recording_index  = ri;
      row.typed                 = typed;
      row.typed_rsp             = r;
      script = {script, row};
   endfunction

   function automatic void add_register(logic [CSR_IDX_W-1:0] idx,
                                        logic [CSR_DATA_W-1:0] val);
      script_row_type row;
      row.is_register = 1'b1;
      row.reg_index   = idx;
      row.reg_value   = val;
      row.word        = '0;
      row.typed       = 1'b0;
      row.typed_rsp   = '0;
      script = {script, row};
   endfunction

   task automatic send_word(req_type w, bit typed, rsp_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      typed_pending = typed;
      typed_value   = r;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_results(int tail);
      req_valid <= 1'b0;
      @(negedge clock);
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   initial begin : stimulus
      static int phase_limit [PHASES]      = '{256, 1, 7, 511, 24, 3};
      static int phase_bpt [PHASES]        = '{16, 1, 9, 31, 0, 5};
      static int phase_delay [PHASES]      = '{3, 0, 255, 2, 1, 6};
      static int phase_send_idle [PHASES]  = '{0, 62, 0, 12, 0, 62};
      static int phase_recv_stall [PHASES] = '{0, 0, 62, 12, 0, 0};
      int      held_slots [$];
      int      pick;
      req_type w;

      // defaults after reset: 256 slots, 4 bytes per texel, delay 3
      add_word(ACT_QUERY, 8'd0, 64'd0, 1'b1, make_rsp(STS_OK, 0, 0, 0, 0, 0, 256));
      add_word(ACT_QUERY, 8'd255, '1, 1'b1, make_rsp(STS_OK, 0, 18865920, 0, 0, 0, 256));
      add_word(ACT_RELEASE, 8'd5, 64'd0, 1'b1, make_rsp(STS_NOT_HELD, 0, 0, 0, 0, 0, 256));
      add_word(ACT_RESERVE, 8'd0, 64'd0, 1'b1, make_rsp(STS_OK, 0, 0, 0, 1, 0, 255));
      add_word(ACT_RESERVE, 8'd0, 64'd0, 1'b1, make_rsp(STS_OK, 1, 73984, 0, 2, 0, 254));
      add_word(ACT_RESERVE, 8'd0, 64'd0);
      add_word(ACT_RELEASE, 8'd0, 64'd10);
      add_word(ACT_RECLAIM, 8'd0, 64'd12);
      add_word(ACT_RELEASE, 8'd1, '1);
      add_word(ACT_RECLAIM, 8'd0, 64'd13);
      add_word(ACT_RELEASE, 8'd0, 64'd14, 1'b1, make_rsp(STS_NOT_HELD, 0, 0, 0, 1, 1, 254));
      add_word(ACT_RECLAIM, 8'd0, '1);
      add_register(CSR_RECLAIM_DELAY, 9'd0);
      add_word(ACT_RECLAIM, 8'd0, '1);
      add_register(CSR_SLOT_LIMIT, 9'd0);
      add_register(CSR_NO_REGISTER, 9'h1FF);
      add_word(ACT_RESERVE, 8'hFF, 64'd0);
      add_register(CSR_SLOT_LIMIT, 9'd2);
      add_word(ACT_RESERVE, 8'd0, 64'd0, 1'b1, make_rsp(STS_OK, 0, 0, 0, 1, 0, 1));
      add_word(ACT_RESERVE, 8'd0, 64'd0);
      add_word(ACT_RESERVE, 8'd0, 64'd0, 1'b1, make_rsp(STS_EXHAUSTED, 0, 0, 0, 2, 0, 0));
      add_word(ACT_QUERY, 8'd2, 64'd0, 1'b1, make_rsp(STS_NO_SLOT, 0, 0, 0, 2, 0, 0));
      add_word(ACT_RELEASE, 8'd255, 64'd0, 1'b1, make_rsp(STS_NO_SLOT, 0, 0, 0, 2, 0, 0));
      add_register(CSR_BYTES_PER_TEXEL, 9'd0);
      add_register(CSR_BYTES_PER_TEXEL, 9'd31);
      add_register(CSR_SLOT_LIMIT, 9'h1FF);
      add_register(CSR_RECLAIM_DELAY, 9'd255);
      add_word(ACT_QUERY, 8'd255, 64'd0, 1'b1,
               make_rsp(STS_OK, 0, 75463680, 0, 0, 0, 256));
      add_word(ACT_RESERVE, 8'd0, 64'd0, 1'b1, make_rsp(STS_OK, 0, 0, 0, 1, 0, 255));
      add_word(ACT_RELEASE, 8'd0, 64'd0);
      add_word(ACT_RECLAIM, 8'd0, 64'd254);
      add_word(ACT_RECLAIM, 8'd0, 64'd255);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[k]) begin
         if (script[k].is_register) begin
            drain_results(4);
            write_register(script[k].reg_index, script[k].reg_value);
         end else begin
            send_word(script[k].word, script[k].typed, script[k].typed_rsp);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_results(4);
         write_register(CSR_SLOT_LIMIT, CSR_DATA_W'(phase_limit[p]));
         write_register(CSR_BYTES_PER_TEXEL, CSR_DATA_W'(phase_bpt[p]));
         write_register(CSR_RECLAIM_DELAY, CSR_DATA_W'(phase_delay[p]));
         send_idle_pct  = phase_send_idle[p];
         recv_stall_pct = phase_recv_stall[p];
         if (p == 3)
            recording_now = 64'hFFFF_FFFF_FFFF_FF00;
         else if (p == 2)
            recording_now = {$urandom, $urandom};
         else
            recording_now = 64'($urandom_range(0, 1000));
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p == 4 && n == 10)
               hold_stretch = 400;
            if (p == 5 && n == 40)
               drain_results(0);
            recording_now = recording_now + 64'($urandom_range(0, cfg_delay / 16 + 2));
            pick = $urandom_range(99);
            w.slot_number = 8'($urandom_range(0, 255));
            w.recording_index = ($urandom_range(99) < 6) ? {$urandom, $urandom} : recording_now;
            if (pick < 35) begin
               w.action = ACT_RESERVE;
            end else if (pick < 65) begin
               w.action = ACT_RELEASE;
               held_slots.delete();
               for (int i = 0; i < cfg_limit; i++)
                  if (slot_state[i] == COND_HELD)
                     held_slots = {held_slots, i};
               if (pick < 60 && held_slots.size() != 0)
                  w.slot_number = 8'(held_slots[$urandom_range(0, held_slots.size() - 1)]);
            end else if (pick < 82) begin
               w.action = ACT_RECLAIM;
            end else begin
               w.action = ACT_QUERY;
               if (pick < 95)
                  w.slot_number = 8'($urandom_range(0, cfg_limit));
            end
            send_word(w, 1'b0, '0);
         end
      end

      drain_results(600);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: deferred_reclaim_slot_allocator_top.f
hw/rtl/drsa_pkg.sv
hw/rtl/drsa_ram.sv
hw/rtl/deferred_reclaim_slot_allocator_top.sv
tb/deferred_reclaim_slot_allocator_top_test.sv
